// ===== hw/rtl/gcm_pkg.sv =====
// Shared types, constants and helpers for the Gabor convolution magnitude block.
`default_nettype none

package gcm_pkg;

	localparam int PIX_W     = 8;
	localparam int COEF_W    = 16;
	localparam int CIDX_W    = 5;
	localparam int MAG_W     = 28;
	localparam int COORD_W   = 10;
	localparam int CFG_W     = 11;
	localparam int CFG_IDX_W = 1;

	localparam int CFG_WIDTH_RST  = 640;
	localparam int CFG_HEIGHT_RST = 480;

	localparam int QDEPTH = 4;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_IMAGE_WIDTH  = 1'b0,
		CFG_IMAGE_HEIGHT = 1'b1
	} gcm_cfg_idx_t;

	typedef enum logic {
		GCM_PIXEL = 1'b0,
		GCM_COEF  = 1'b1
	} gcm_kind_t;

	typedef struct packed {
		logic               emit;
		logic               last_of_frame;
		logic [COORD_W-1:0] out_x;
		logic [COORD_W-1:0] out_y;
	} gcm_meta_t;

	typedef struct packed {
		gcm_kind_t                 kind;
		logic [PIX_W-1:0]          pixel;
		logic [CIDX_W-1:0]         coef_index;
		logic signed [COEF_W-1:0]  coef_value;
		gcm_meta_t                 meta;
	} gcm_item_t;

	function automatic int gcm_clamp(input logic [CFG_W-1:0] v, input int lo, input int hi);
		int r;
		r = int'(v);
		if (r < lo)
			r = lo;
		else if (r > hi)
			r = hi;
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/gcm_in_if.sv =====
// Input channel: pixel and coefficient-load items.
`default_nettype none

interface gcm_in_if;
	import gcm_pkg::*;

	logic                      valid;
	logic                      ready;
	logic                      req_type;
	logic [PIX_W-1:0]          pixel;
	logic                      frame_start;
	logic [CIDX_W-1:0]         coef_index;
	logic signed [COEF_W-1:0]  coef_value;

	modport source (
		output valid, req_type, pixel, frame_start, coef_index, coef_value,
		input  ready
	);

	modport sink (
		input  valid, req_type, pixel, frame_start, coef_index, coef_value,
		output ready
	);
endinterface

`default_nettype wire

// ===== hw/rtl/gcm_out_if.sv =====
// Output channel: filter magnitude with output coordinates.
`default_nettype none

interface gcm_out_if;
	import gcm_pkg::*;

	logic               valid;
	logic               ready;
	logic [MAG_W-1:0]   magnitude;
	logic [COORD_W-1:0] out_x;
	logic [COORD_W-1:0] out_y;
	logic               last_of_frame;

	modport source (
		output valid, magnitude, out_x, out_y, last_of_frame,
		input  ready
	);

	modport sink (
		input  valid, magnitude, out_x, out_y, last_of_frame,
		output ready
	);
endinterface

`default_nettype wire

// ===== hw/rtl/gcm_queue.sv =====
// Small FIFO between the classifying front end and the filter back end.
`default_nettype none

module gcm_queue #(
	parameter int W     = 8,
	parameter int DEPTH = 4
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         push,
	input  wire logic [W-1:0] push_data,
	output logic              full,
	input  wire logic         pop,
	output logic              head_valid,
	output logic [W-1:0]      head_data
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [W-1:0]  mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] cnt_q;
	logic          do_push;
	logic          do_pop;

	assign full       = (cnt_q == CW'(DEPTH));
	assign head_valid = (cnt_q != '0);
	assign head_data  = mem_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + CW'(1);
				2'b01:   cnt_q <= cnt_q - CW'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end
endmodule

`default_nettype wire

// ===== hw/rtl/gcm_front.sv =====
// Front end: size registers, raster position counters and item classification.
`default_nettype none

module gcm_front #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024,
	parameter int RADIUS     = 2
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	gcm_in_if.sink                               req,
	input  wire logic                            cfg_we,
	input  wire logic [gcm_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [gcm_pkg::CFG_W-1:0]       cfg_data,
	input  wire logic                            clr_busy,
	input  wire logic                            q_full,
	output logic                                 q_push,
	output gcm_pkg::gcm_item_t                   q_item,
	output logic [$clog2(MAX_WIDTH)-1:0]         q_lc
);
	import gcm_pkg::*;

	localparam int KSIZE = 2 * RADIUS + 1;
	localparam int LA    = $clog2(MAX_WIDTH);
	localparam int CW    = $clog2(MAX_WIDTH + 1);
	localparam int RW    = $clog2(MAX_HEIGHT + 1);
	localparam int XW    = (CW > COORD_W) ? CW : COORD_W;
	localparam int YW    = (RW > COORD_W) ? RW : COORD_W;
	localparam logic [CW-1:0] WIDTH_RST  =
		CW'(gcm_clamp(CFG_W'(CFG_WIDTH_RST), KSIZE, MAX_WIDTH));
	localparam logic [RW-1:0] HEIGHT_RST =
		RW'(gcm_clamp(CFG_W'(CFG_HEIGHT_RST), KSIZE, MAX_HEIGHT));

	logic [CW-1:0] width_q;
	logic [RW-1:0] height_q;
	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;

	logic [CW-1:0] col_cur;
	logic [RW-1:0] row_cur;
	logic [CW-1:0] col_inc;
	logic [RW-1:0] row_inc;
	logic          wrap_col;
	logic          wrap_row;
	logic [XW-1:0] x_full;
	logic [YW-1:0] y_full;
	gcm_kind_t     kind;

	assign req.ready = !clr_busy && !q_full;
	assign q_push    = req.valid && req.ready;
	assign kind      = gcm_kind_t'(req.req_type);

	always_comb begin
		col_cur  = req.frame_start ? '0 : col_q;
		row_cur  = req.frame_start ? '0 : row_q;
		col_inc  = col_cur + CW'(1);
		row_inc  = row_cur + RW'(1);
		wrap_col = (col_inc >= width_q);
		wrap_row = (row_inc >= height_q);
		x_full   = XW'(col_cur) - XW'(2 * RADIUS);
		y_full   = YW'(row_cur) - YW'(2 * RADIUS);
	end

	always_comb begin
		q_item.kind               = kind;
		q_item.pixel              = req.pixel;
		q_item.coef_index         = req.coef_index;
		q_item.coef_value         = req.coef_value;
		q_item.meta.emit          = (kind == GCM_PIXEL) &&
			(col_cur >= CW'(2 * RADIUS)) && (row_cur >= RW'(2 * RADIUS));
		q_item.meta.last_of_frame = wrap_col && wrap_row;
		q_item.meta.out_x         = x_full[COORD_W-1:0];
		q_item.meta.out_y         = y_full[COORD_W-1:0];
		q_lc                      = col_cur[LA-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RST;
			height_q <= HEIGHT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_IMAGE_WIDTH:  width_q  <= CW'(gcm_clamp(cfg_data, KSIZE, MAX_WIDTH));
				CFG_IMAGE_HEIGHT: height_q <= RW'(gcm_clamp(cfg_data, KSIZE, MAX_HEIGHT));
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (q_push && kind == GCM_PIXEL) begin
			if (wrap_col) begin
				col_q <= '0;
				row_q <= wrap_row ? '0 : row_inc;
			end else begin
				col_q <= col_inc;
				row_q <= row_cur;
			end
		end
	end
endmodule

`default_nettype wire

// ===== hw/rtl/gcm_back.sv =====
// Back end: line store, window, kernel store, multiply-add tree and output register.
`default_nettype none

module gcm_back #(
	parameter int MAX_WIDTH = 1024,
	parameter int RADIUS    = 2
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          head_valid,
	input  wire gcm_pkg::gcm_item_t            head_item,
	input  wire logic [$clog2(MAX_WIDTH)-1:0]  head_lc,
	output logic                               pop,
	output logic                               clr_busy,
	gcm_out_if.source                          rsp
);
	import gcm_pkg::*;

	localparam int KSIZE = 2 * RADIUS + 1;
	localparam int KTAPS = KSIZE * KSIZE;
	localparam int LA    = $clog2(MAX_WIDTH);
	localparam int LW    = (KSIZE - 1) * PIX_W;
	localparam int PW    = COEF_W + PIX_W + 1;
	localparam int AW    = PW + $clog2(KTAPS);

	// line store: one word per column, KSIZE-1 previous rows
	logic [LW-1:0] line_mem [MAX_WIDTH];

	logic          clr_busy_q;
	logic [LA-1:0] clr_addr_q;

	logic          en;

	logic          valid_s1;
	gcm_item_t     item_s1;
	logic [LA-1:0] lc_s1;
	logic [LW-1:0] rdata_s1;

	logic          fwd_valid_q;
	logic [LA-1:0] fwd_addr_q;
	logic [LW-1:0] fwd_data_q;

	logic [LW-1:0] col_old;
	logic [LW-1:0] col_new;
	logic          pix_s1;

	logic          mem_we;
	logic [LA-1:0] mem_waddr;
	logic [LW-1:0] mem_wdata;

	logic [PIX_W-1:0] window_q [KTAPS];
	logic signed [COEF_W-1:0] kernel_q [KTAPS];

	logic          valid_s2;
	gcm_item_t     item_s2;

	logic signed [PW-1:0] prod_d  [KTAPS];
	logic signed [PW-1:0] prod_s3 [KTAPS];
	gcm_meta_t            meta_s3;

	logic signed [AW-1:0] rsum_d  [KSIZE];
	logic signed [AW-1:0] rsum_s4 [KSIZE];
	gcm_meta_t            meta_s4;

	logic signed [AW-1:0] acc_d;
	logic signed [AW-1:0] acc_s5;
	gcm_meta_t            meta_s5;

	logic [AW-1:0]        mag_abs;

	logic                 out_valid_q;
	logic [MAG_W-1:0]     magnitude_q;
	logic [COORD_W-1:0]   out_x_q;
	logic [COORD_W-1:0]   out_y_q;
	logic                 last_q;

	assign en       = !out_valid_q || rsp.ready;
	assign pop      = en && head_valid && !clr_busy_q;
	assign clr_busy = clr_busy_q;

	// clearing pass after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			if (clr_addr_q == LA'(MAX_WIDTH - 1))
				clr_busy_q <= 1'b0;
			else
				clr_addr_q <= clr_addr_q + LA'(1);
		end
	end

	// stage 1: line store read
	always_ff @(posedge clk) begin
		if (pop)
			rdata_s1 <= line_mem[head_lc];
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			line_mem[mem_waddr] <= mem_wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= pop;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			item_s1 <= head_item;
			lc_s1   <= head_lc;
		end
	end

	// read-after-write bypass for back-to-back transfers on one column
	always_comb begin
		pix_s1  = valid_s1 && (item_s1.kind == GCM_PIXEL);
		col_old = (fwd_valid_q && fwd_addr_q == lc_s1) ? fwd_data_q : rdata_s1;
		for (int r = 0; r < KSIZE - 2; r++)
			col_new[r*PIX_W +: PIX_W] = col_old[(r+1)*PIX_W +: PIX_W];
		col_new[(KSIZE-2)*PIX_W +: PIX_W] = item_s1.pixel;
	end

	always_comb begin
		if (clr_busy_q) begin
			mem_we    = 1'b1;
			mem_waddr = clr_addr_q;
			mem_wdata = '0;
		end else begin
			mem_we    = en && pix_s1;
			mem_waddr = lc_s1;
			mem_wdata = col_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_valid_q <= 1'b0;
		end else if (en) begin
			fwd_valid_q <= pix_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			fwd_addr_q <= lc_s1;
			fwd_data_q <= col_new;
		end
	end

	// window shift
	always_ff @(posedge clk) begin
		if (en && pix_s1) begin
			for (int r = 0; r < KSIZE; r++) begin
				for (int k = 0; k < KSIZE - 1; k++)
					window_q[r*KSIZE + k] <= window_q[r*KSIZE + k + 1];
			end
			for (int r = 0; r < KSIZE - 1; r++)
				window_q[r*KSIZE + KSIZE - 1] <= col_old[r*PIX_W +: PIX_W];
			window_q[KTAPS - 1] <= item_s1.pixel;
		end
	end

	// stage 2: coefficient load and products
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en)
			item_s2 <= item_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < KTAPS; i++)
				kernel_q[i] <= '0;
		end else if (en && valid_s2 && item_s2.kind == GCM_COEF) begin
			for (int i = 0; i < KTAPS; i++) begin
				if (int'(item_s2.coef_index) == i)
					kernel_q[i] <= item_s2.coef_value;
			end
		end
	end

	always_comb begin
		for (int i = 0; i < KTAPS; i++)
			prod_d[i] = PW'(kernel_q[i]) * PW'($signed({1'b0, window_q[i]}));
	end

	// stages 3 to 5: row sums, total, magnitude
	always_comb begin
		for (int r = 0; r < KSIZE; r++) begin
			rsum_d[r] = '0;
			for (int k = 0; k < KSIZE; k++)
				rsum_d[r] = rsum_d[r] + AW'(prod_s3[r*KSIZE + k]);
		end
		acc_d = '0;
		for (int r = 0; r < KSIZE; r++)
			acc_d = acc_d + rsum_s4[r];
		mag_abs = acc_s5[AW-1] ? AW'(-acc_s5) : AW'(acc_s5);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			meta_s3     <= '0;
			meta_s4     <= '0;
			meta_s5     <= '0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			meta_s3     <= '{
				emit:          valid_s2 && (item_s2.kind == GCM_PIXEL) && item_s2.meta.emit,
				last_of_frame: item_s2.meta.last_of_frame,
				out_x:         item_s2.meta.out_x,
				out_y:         item_s2.meta.out_y
			};
			meta_s4     <= meta_s3;
			meta_s5     <= meta_s4;
			out_valid_q <= meta_s5.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < KTAPS; i++)
				prod_s3[i] <= prod_d[i];
			for (int r = 0; r < KSIZE; r++)
				rsum_s4[r] <= rsum_d[r];
			acc_s5      <= acc_d;
			magnitude_q <= mag_abs[MAG_W-1:0];
			out_x_q     <= meta_s5.out_x;
			out_y_q     <= meta_s5.out_y;
			last_q      <= meta_s5.last_of_frame;
		end
	end

	assign rsp.valid         = out_valid_q;
	assign rsp.magnitude     = magnitude_q;
	assign rsp.out_x         = out_x_q;
	assign rsp.out_y         = out_y_q;
	assign rsp.last_of_frame = last_q;
endmodule

`default_nettype wire

// ===== hw/rtl/gabor_convolution_magnitude.sv =====
// Top level of the streaming Gabor convolution magnitude filter.
`default_nettype none

// Raster-order pixel filter with a (2*RADIUS+1)-square signed Q1.15 kernel over
// the valid region; kernel entries are loaded by coefficient transfers on the same
// channel and take effect for every pixel that follows them. One item (pixel or
// coefficient) is taken per clock while the output side keeps up; a pixel's result
// passes through a four-entry queue, the line store read, the window shift, the
// product stage, a row-sum stage and a total stage into the output register. The
// line store is a single memory of MAX_WIDTH words updated by a read-modify-write
// per pixel, with a bypass for repeated columns. After reset the line store is
// cleared, during which no item is taken (size writes are taken at any time). The
// user must write the size registers only while idle; the block does not enforce it.
module gabor_convolution_magnitude #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024,
	parameter int RADIUS     = 2
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	gcm_in_if.sink                             req,
	gcm_out_if.source                          rsp,
	input  wire logic                          cfg_we,
	input  wire logic [gcm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [gcm_pkg::CFG_W-1:0]     cfg_data
);
	import gcm_pkg::*;

	localparam int LA = $clog2(MAX_WIDTH);
	localparam int IW = $bits(gcm_item_t);
	localparam int QW = IW + LA;

	logic          q_push;
	gcm_item_t     q_item;
	logic [LA-1:0] q_lc;
	logic          q_full;
	logic          q_pop;
	logic          head_valid;
	logic [QW-1:0] head_data;
	gcm_item_t     head_item;
	logic [LA-1:0] head_lc;
	logic          clr_busy;

	gcm_front #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT),
		.RADIUS     (RADIUS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.clr_busy  (clr_busy),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_item    (q_item),
		.q_lc      (q_lc)
	);

	gcm_queue #(
		.W     (QW),
		.DEPTH (QDEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_data  ({q_lc, q_item}),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (head_valid),
		.head_data  (head_data)
	);

	assign head_item = head_data[IW-1:0];
	assign head_lc   = head_data[QW-1:IW];

	gcm_back #(
		.MAX_WIDTH (MAX_WIDTH),
		.RADIUS    (RADIUS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_item  (head_item),
		.head_lc    (head_lc),
		.pop        (q_pop),
		.clr_busy   (clr_busy),
		.rsp        (rsp)
	);
endmodule

`default_nettype wire

// ===== sim/tb_gabor_convolution_magnitude.sv =====
// Testbench for gabor_convolution_magnitude: random stream checked against a built-in predictor.
`default_nettype none

module tb_gabor_convolution_magnitude;
	import gcm_pkg::*;

	localparam int MAX_W         = 1024;
	localparam int MAX_H         = 1024;
	localparam int RAD           = 2;
	localparam int KDIM          = 2 * RAD + 1;
	localparam int KTAPS         = KDIM * KDIM;
	localparam int DRAIN_CYCLES  = 24;
	localparam int HOLD_CYCLES   = 300;
	localparam int CYCLE_LIMIT   = 250000;
	localparam int RANDOM_ITEMS  = 810;
	localparam int SETTING_ITEMS = 100;
	localparam int WIDE_PIXELS   = 120;

	typedef struct packed {
		gcm_kind_t                kind;
		logic [PIX_W-1:0]         pixel;
		logic                     frame_start;
		logic [CIDX_W-1:0]        coef_index;
		logic signed [COEF_W-1:0] coef_value;
	} filter_req_t;

	typedef struct packed {
		logic [MAG_W-1:0]   magnitude;
		logic [COORD_W-1:0] out_x;
		logic [COORD_W-1:0] out_y;
		logic               last;
	} filter_resp_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0] cfg_data;

	gcm_in_if  req_ch ();
	gcm_out_if rsp_ch ();

	gabor_convolution_magnitude #(
		.MAX_WIDTH (MAX_W),
		.MAX_HEIGHT(MAX_H),
		.RADIUS    (RAD)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req_ch),
		.rsp      (rsp_ch),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always #4 clk = ~clk;

	// predictor state
	logic [CFG_W-1:0]         width_raw, height_raw;
	logic [PIX_W-1:0]         line_mem [KDIM-1][MAX_W];
	logic [PIX_W-1:0]         win [KDIM][KDIM];
	logic signed [COEF_W-1:0] taps [KTAPS];
	int unsigned              col_pos, row_pos;

	filter_req_t  pending_reqs[$];
	filter_resp_t expected_responses[$];

	int unsigned queued_count, accepted_count, results_checked, mismatch_count;
	int unsigned pixel_count, coef_count, size_settings, cycle_count;
	int unsigned idle_mode, stall_requests, stalls_served, hold_left;
	logic        holding = 1'b0;
	longint unsigned max_mag_seen;

	function automatic int unsigned eff_size(input logic [CFG_W-1:0] raw, input int unsigned hi);
		if (raw < KDIM)
			return KDIM;
		if (raw > hi)
			return hi;
		return 32'(raw);
	endfunction

	function automatic void apply_filter_item(input filter_req_t it);
		int unsigned w, h, col, lc;
		longint acc;
		longint unsigned mag;
		filter_resp_t r;
		w = eff_size(width_raw, MAX_W);
		h = eff_size(height_raw, MAX_H);
		if (it.kind == GCM_COEF) begin
			if (it.coef_index < KTAPS)
				taps[it.coef_index] = it.coef_value;
			return;
		end
		if (it.frame_start) begin
			col_pos = 0;
			row_pos = 0;
		end
		col = col_pos;
		lc = col % MAX_W;
		for (int y = 0; y < KDIM; y++)
			for (int x = 0; x < KDIM - 1; x++)
				win[y][x] = win[y][x+1];
		for (int y = 0; y < KDIM - 1; y++)
			win[y][KDIM-1] = line_mem[y][lc];
		win[KDIM-1][KDIM-1] = it.pixel;
		for (int y = 0; y < KDIM - 2; y++)
			line_mem[y][lc] = line_mem[y+1][lc];
		line_mem[KDIM-2][lc] = it.pixel;
		if (col >= 2 * RAD && row_pos >= 2 * RAD) begin
			acc = 0;
			for (int y = 0; y < KDIM; y++)
				for (int x = 0; x < KDIM; x++)
					acc += longint'(taps[y*KDIM+x]) * longint'(win[y][x]);
			mag = (acc < 0) ? -acc : acc;
			r.magnitude = mag[MAG_W-1:0];
			r.out_x = COORD_W'(col - 2 * RAD);
			r.out_y = COORD_W'(row_pos - 2 * RAD);
			r.last = (col + 1 >= w) && (row_pos + 1 >= h);
			expected_responses.push_back(r);
		end
		col_pos = col + 1;
		if (col_pos >= w) begin
			col_pos = 0;
			row_pos++;
			if (row_pos >= h)
				row_pos = 0;
		end
	endfunction

	function automatic int unsigned sender_idle_pct();
		case (idle_mode)
			0: return 17;
			1: return 46;
			default: return 0;
		endcase
	endfunction

	function automatic int unsigned receiver_idle_pct();
		case (idle_mode)
			0: return 46;
			1: return 17;
			default: return 0;
		endcase
	endfunction

	task automatic report_mismatch(input string what, input longint unsigned got,
			input longint unsigned want);
		$display("MISMATCH %s: got %0d, expected %0d (response %0d)", what, got, want,
			results_checked);
		mismatch_count++;
	endtask

	// driver: predicts on each transfer, then offers the next item
	always @(posedge clk) begin
		filter_req_t nxt;
		filter_req_t cur;
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
		end else begin
			if (req_ch.valid && req_ch.ready) begin
				cur.kind        = gcm_kind_t'(req_ch.req_type);
				cur.pixel       = req_ch.pixel;
				cur.frame_start = req_ch.frame_start;
				cur.coef_index  = req_ch.coef_index;
				cur.coef_value  = req_ch.coef_value;
				apply_filter_item(cur);
				accepted_count++;
			end
			if (!req_ch.valid || req_ch.ready) begin
				if (pending_reqs.size() != 0 && $urandom_range(99) >= sender_idle_pct()) begin
					nxt = pending_reqs.pop_front();
					req_ch.valid       <= 1'b1;
					req_ch.req_type    <= nxt.kind;
					req_ch.pixel       <= nxt.pixel;
					req_ch.frame_start <= nxt.frame_start;
					req_ch.coef_index  <= nxt.coef_index;
					req_ch.coef_value  <= nxt.coef_value;
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
		end
	end

	// long receiver hold-off, counted in cycles
	always @(posedge clk) begin
		if (stalls_served != stall_requests) begin
			stalls_served++;
			hold_left = HOLD_CYCLES;
		end else if (hold_left > 0) begin
			hold_left--;
		end
		holding <= (hold_left != 0);
	end

	// monitor: checks responses, drives ready with random stalls
	always @(posedge clk) begin
		filter_resp_t want;
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (expected_responses.size() == 0) begin
					report_mismatch("response with none expected", 64'(rsp_ch.magnitude),
						64'd0);
				end else begin
					want = expected_responses.pop_front();
					if (rsp_ch.magnitude !== want.magnitude)
						report_mismatch("magnitude", 64'(rsp_ch.magnitude),
							64'(want.magnitude));
					if (rsp_ch.out_x !== want.out_x)
						report_mismatch("out_x", 64'(rsp_ch.out_x), 64'(want.out_x));
					if (rsp_ch.out_y !== want.out_y)
						report_mismatch("out_y", 64'(rsp_ch.out_y), 64'(want.out_y));
					if (rsp_ch.last_of_frame !== want.last)
						report_mismatch("last_of_frame", 64'(rsp_ch.last_of_frame),
							64'(want.last));
					if (64'(want.magnitude) > max_mag_seen)
						max_mag_seen = 64'(want.magnitude);
				end
				results_checked++;
			end
			if (holding)
				rsp_ch.ready <= 1'b0;
			else
				rsp_ch.ready <= ($urandom_range(99) >= receiver_idle_pct());
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d responses outstanding", cycle_count,
				expected_responses.size());
			$display("end of test: mismatches");
			$finish;
		end
	end

	task automatic push_pixel(input logic [PIX_W-1:0] px, input logic fs);
		filter_req_t it;
		it.kind        = GCM_PIXEL;
		it.pixel       = px;
		it.frame_start = fs;
		it.coef_index  = CIDX_W'($urandom);
		it.coef_value  = COEF_W'($urandom);
		pending_reqs.push_back(it);
		queued_count++;
		pixel_count++;
	endtask

	task automatic push_coef(input logic [CIDX_W-1:0] idx, input logic signed [COEF_W-1:0] v);
		filter_req_t it;
		it.kind        = GCM_COEF;
		it.pixel       = PIX_W'($urandom);
		it.frame_start = 1'($urandom);
		it.coef_index  = idx;
		it.coef_value  = v;
		pending_reqs.push_back(it);
		queued_count++;
		coef_count++;
	endtask

	task automatic load_kernel(input int unsigned pattern);
		logic signed [COEF_W-1:0] v;
		for (int t = 0; t < KTAPS; t++) begin
			case (pattern)
				0: v = 16'sh8000;
				1: v = 16'sh7fff;
				2: v = COEF_W'($urandom);
				default: v = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
			endcase
			push_coef(CIDX_W'(t), v);
		end
	endtask

	task automatic write_size(input gcm_cfg_idx_t idx, input logic [CFG_W-1:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		if (idx == CFG_IMAGE_WIDTH)
			width_raw = val;
		else
			height_raw = val;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_sizes(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
		write_size(CFG_IMAGE_WIDTH, w);
		write_size(CFG_IMAGE_HEIGHT, h);
		size_settings++;
	endtask

	task automatic drain();
		while (accepted_count != queued_count || expected_responses.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// a frame of random or constant pixels; some are cut short, lack a start mark,
	// carry stray start marks or kernel updates mid-frame, or are plain noise
	task automatic gen_frame(input int unsigned w, input int unsigned h);
		int unsigned variant, style, len;
		logic [PIX_W-1:0] px;
		logic fs;
		variant = $urandom_range(9);
		case ($urandom_range(9))
			0, 1, 2: load_kernel($urandom_range(3));
			3, 4: repeat ($urandom_range(1, 4))
				push_coef(CIDX_W'($urandom_range(31)), COEF_W'($urandom));
			default: ;
		endcase
		style = $urandom_range(9);
		len = (variant == 7) ? $urandom_range(1, w * h - 1) : w * h;
		for (int i = 0; i < len; i++) begin
			px = (style == 0) ? 8'hff : (style == 1) ? 8'h00 : PIX_W'($urandom);
			fs = (i == 0) && (variant != 6);
			if (variant == 9)
				fs = ($urandom_range(9) == 0);
			if (variant == 8 && $urandom_range(15) == 0)
				push_coef(CIDX_W'($urandom_range(KTAPS - 1)), COEF_W'($urandom));
			push_pixel(px, fs);
		end
	endtask

	initial begin
		int unsigned phase_start, setting_start, w, h;
		logic [CFG_W-1:0] raw_w, raw_h;
		arst_n             = 1'b0;
		cfg_we             = 1'b0;
		cfg_index          = CFG_IMAGE_WIDTH;
		cfg_data           = '0;
		req_ch.valid       = 1'b0;
		req_ch.req_type    = GCM_PIXEL;
		req_ch.pixel       = '0;
		req_ch.frame_start = 1'b0;
		req_ch.coef_index  = '0;
		req_ch.coef_value  = '0;
		rsp_ch.ready       = 1'b0;
		width_raw  = CFG_W'(CFG_WIDTH_RST);
		height_raw = CFG_W'(CFG_HEIGHT_RST);
		for (int y = 0; y < KDIM - 1; y++)
			for (int x = 0; x < MAX_W; x++)
				line_mem[y][x] = '0;
		for (int y = 0; y < KDIM; y++)
			for (int x = 0; x < KDIM; x++)
				win[y][x] = '0;
		for (int t = 0; t < KTAPS; t++)
			taps[t] = '0;
		col_pos = 0;
		row_pos = 0;
		idle_mode = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// directed: undersized registers clamp to a 5x5 frame, kernel extremes,
		// out-of-range loads, ignored fields on both kinds of item
		set_sizes(CFG_W'(0), CFG_W'(3));
		push_coef(CIDX_W'(0), 16'sh8000);
		push_coef(CIDX_W'(24), 16'sh7fff);
		push_coef(CIDX_W'(12), 16'sh8000);
		push_coef(CIDX_W'(25), 16'sh1234);
		push_coef(CIDX_W'(31), 16'shffff);
		for (int i = 0; i < KTAPS; i++)
			push_pixel((i % 2) ? 8'hff : 8'h00, i == 0);
		drain();

		// random phases under the three idling schemes
		for (int mode = 0; mode < 3; mode++) begin
			idle_mode = mode;
			phase_start = queued_count;
			while (queued_count - phase_start < RANDOM_ITEMS / 3) begin
				raw_w = ($urandom_range(9) == 0) ? CFG_W'($urandom_range(0, 4)) :
					CFG_W'($urandom_range(5, 14));
				raw_h = ($urandom_range(9) == 0) ? CFG_W'($urandom_range(0, 4)) :
					CFG_W'($urandom_range(5, 10));
				drain();
				set_sizes(raw_w, raw_h);
				w = eff_size(raw_w, MAX_W);
				h = eff_size(raw_h, MAX_H);
				if (mode != 1 && queued_count == phase_start)
					stall_requests++;
				setting_start = queued_count;
				while (queued_count - setting_start < SETTING_ITEMS)
					gen_frame(w, h);
			end
		end

		// oversized width register clamps to the maximum: reach the first full row in a
		// narrow frame, then widen so that row runs on past the narrow width
		drain();
		set_sizes(CFG_W'(5), CFG_W'(5));
		load_kernel(2);
		for (int i = 0; i < 4 * 5; i++)
			push_pixel(PIX_W'($urandom), i == 0);
		drain();
		set_sizes(CFG_W'(2047), CFG_W'(5));
		for (int i = 0; i < WIDE_PIXELS; i++)
			push_pixel(PIX_W'($urandom), 1'b0);

		// tall frame cut short, then height shrunk below the current row
		drain();
		set_sizes(CFG_W'(4), CFG_W'(1024));
		load_kernel(3);
		for (int i = 0; i < 100; i++)
			push_pixel(PIX_W'($urandom), i == 0);
		drain();
		set_sizes(CFG_W'(4), CFG_W'(6));
		for (int i = 0; i < 47; i++)
			push_pixel(PIX_W'($urandom), 1'b0);
		drain();

		$display("covered %0d pixel and %0d coefficient transfers over %0d size settings",
			pixel_count, coef_count, size_settings);
		$display("checked %0d filter responses, largest magnitude %0d",
			results_checked, max_mag_seen);
		if (mismatch_count == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

`default_nettype wire

// ===== sim.f =====
hw/rtl/gcm_pkg.sv
hw/rtl/gcm_in_if.sv
hw/rtl/gcm_out_if.sv
hw/rtl/gcm_queue.sv
hw/rtl/gcm_front.sv
hw/rtl/gcm_back.sv
hw/rtl/gabor_convolution_magnitude.sv
sim/tb_gabor_convolution_magnitude.sv
